// ===== design/sfd_pkg.sv =====
// Shared types and constants for the SLIP frame decoder.
// No dependencies; the decode, top-level and checker files refer to this package by scoped names.
package sfd_pkg;

   // SLIP special characters.
   localparam logic [7:0] SLIP_END     = 8'hC0;
   localparam logic [7:0] SLIP_ESC     = 8'hDB;
   localparam logic [7:0] SLIP_ESC_END = 8'hDC;
   localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

   // Reset value of the maximum frame length register.
   localparam logic [15:0] MAX_LEN_RESET = 16'd1500;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_END    = 2'd1,
      KIND_OVF    = 2'd2,
      KIND_BADESC = 2'd3
   } kind_type;

   // Deframer state carried from one byte to the next.
   typedef struct packed {
      logic        in_frame;
      logic        escaped;
      logic [15:0] byte_count;
   } state_type;

   // One result, as driven on the response channel.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_byte;
      logic [15:0] frame_len;
      logic        last;
   } result_type;

endpackage

// ===== design/sfd_req_if.sv =====
// Request channel of the SLIP frame decoder: one raw received byte per request.
// Stands alone; no package is needed.
interface sfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/sfd_rsp_if.sv =====
// Response channel of the SLIP frame decoder: decoded bytes, frame ends and errors.
// Stands alone; no package is needed.
interface sfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  out_byte;
   logic [15:0] frame_len;
   logic        last;

   modport source (output valid, output kind, output out_byte, output frame_len,
                   output last, input ready);
   modport sink   (input valid, input kind, input out_byte, input frame_len,
                   input last, output ready);
endinterface

// ===== design/sfd_decode.sv =====
// Combinational decode of one raw byte against the current deframer state.
// Depends on sfd_pkg for the state and result types and the SLIP characters.
module sfd_decode (
   input  sfd_pkg::state_type  state_cur,
   input  logic [7:0]          rx_byte,
   input  logic [15:0]         max_len,
   output sfd_pkg::state_type  state_nxt,
   output logic                has_result,
   output sfd_pkg::result_type result
);

   // Decide the next state and the optional result for this byte.
   always_comb begin
      state_nxt  = state_cur;
      has_result = 1'b0;
      result     = '0;
      result.kind = sfd_pkg::KIND_DATA;

      if (!state_cur.in_frame) begin
         // Hunting: only END opens a frame, everything else is dropped.
         if (rx_byte == sfd_pkg::SLIP_END) begin
            state_nxt.in_frame   = 1'b1;
            state_nxt.escaped    = 1'b0;
            state_nxt.byte_count = '0;
         end
      end else if (state_cur.byte_count == max_len) begin
         // Frame is full: whatever arrives is an overflow.
         state_nxt   = '0;
         has_result  = 1'b1;
         result.kind = sfd_pkg::KIND_OVF;
         result.last = 1'b1;
      end else if (rx_byte == sfd_pkg::SLIP_END) begin
         // END closes the frame; an empty frame reports nothing.
         state_nxt = '0;
         if (state_cur.byte_count != '0) begin
            has_result       = 1'b1;
            result.kind      = sfd_pkg::KIND_END;
            result.frame_len = state_cur.byte_count;
            result.last      = 1'b1;
         end
      end else if (rx_byte == sfd_pkg::SLIP_ESC) begin
         state_nxt.escaped = 1'b1;
      end else if (state_cur.escaped) begin
         // Second byte of an escape sequence.
         case (rx_byte)
            sfd_pkg::SLIP_ESC_ESC: begin
               state_nxt.escaped    = 1'b0;
               state_nxt.byte_count = state_cur.byte_count + 16'd1;
               has_result           = 1'b1;
               result.out_byte      = sfd_pkg::SLIP_ESC;
            end
            sfd_pkg::SLIP_ESC_END: begin
               state_nxt.escaped    = 1'b0;
               state_nxt.byte_count = state_cur.byte_count + 16'd1;
               has_result           = 1'b1;
               result.out_byte      = sfd_pkg::SLIP_END;
            end
            default: begin
               state_nxt   = '0;
               has_result  = 1'b1;
               result.kind = sfd_pkg::KIND_BADESC;
               result.last = 1'b1;
            end
         endcase
      end else begin
         // Plain data byte passes through.
         state_nxt.byte_count = state_cur.byte_count + 16'd1;
         has_result           = 1'b1;
         result.out_byte      = rx_byte;
      end
   end

endmodule

// ===== design/slip_frame_decoder_core.sv =====
// Top level of the SLIP frame decoder: input register, decode, result register.
// Depends on sfd_pkg, sfd_req_if, sfd_rsp_if and sfd_decode.
//
//  Channel | Direction | Payload                             | Handshake
//  --------+-----------+-------------------------------------+---------------------
//  req     | in        | rx_byte[7:0]                        | valid / ready
//  rsp     | out       | kind, out_byte, frame_len, last     | valid / ready
//  csr     | in        | csr_wr_data[15:0] (max_len)         | csr_wr_en, no wait
//
// One byte is accepted per cycle while req ready is high; its result, if any, passes
// through the request register, decode and result register to the response port.
// A byte that causes no result offers nothing on the response port.
// Reset is synchronous and returns to hunting with max_len at its reset value.
// A stalled response holds the result register; the request register then
// holds too, and req ready falls only when both are full.
module slip_frame_decoder_core #(
   parameter logic [15:0] MAX_LEN_RESET = sfd_pkg::MAX_LEN_RESET
) (
   input  logic        clock,
   input  logic        reset,
   sfd_req_if.sink     req_chan,
   sfd_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic                req_vld_ff, req_vld_in;
   logic [7:0]          req_byte_ff;
   logic                rsp_vld_ff, rsp_vld_in;
   sfd_pkg::result_type rsp_data_ff;
   sfd_pkg::state_type  state_ff, state_in;
   logic [15:0]         max_len_ff;
   logic                has_result;
   sfd_pkg::result_type result;
   logic                advance;
   logic                req_take;

   // The held byte moves on when the result register is free or draining.
   assign advance  = req_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !req_vld_ff || advance;

   sfd_decode u_decode (
      .state_cur  (state_ff),
      .rx_byte    (req_byte_ff),
      .max_len    (max_len_ff),
      .state_nxt  (state_in),
      .has_result (has_result),
      .result     (result)
   );

   // Request register.
   assign req_vld_in = req_take || (req_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
      end
      if (req_take) begin
         req_byte_ff <= req_chan.rx_byte;
      end
   end

   // Deframer state and configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= '0;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

   // Result register.
   assign rsp_vld_in = advance ? has_result : (rsp_vld_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      if (advance && has_result) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.kind      = rsp_data_ff.kind;
   assign rsp_chan.out_byte  = rsp_data_ff.out_byte;
   assign rsp_chan.frame_len = rsp_data_ff.frame_len;
   assign rsp_chan.last      = rsp_data_ff.last;

endmodule

// ===== design/sfd_checker.sv =====
// Port-level checks for the SLIP frame decoder, bound to the top level.
// Depends on sfd_pkg for the result kinds.
module sfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [15:0] rsp_frame_len,
   input logic        rsp_last
);

   // A stalled response stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Nothing is offered straight after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response offered after reset");

   // A frame end always carries a non-empty length and closes the frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == sfd_pkg::KIND_END |-> rsp_frame_len != 16'd0 && rsp_last)
      else $error("frame end with empty length or without last");

   // Data bytes never close a frame; errors and ends always do.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != sfd_pkg::KIND_DATA)))
      else $error("last does not match result kind");

endmodule

bind slip_frame_decoder_core sfd_checker u_sfd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_kind      (rsp_chan.kind),
   .rsp_frame_len (rsp_chan.frame_len),
   .rsp_last      (rsp_chan.last)
);
